[rtl/dchr_pkg.sv]
// Shared constants and types for the dominant colour histogram ranker.
`default_nettype none
package dchr_pkg;
   localparam int MAX_COLORS = 64;
   localparam int COUNT_BITS = 24;
   localparam int IDX_BITS   = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
   localparam int USED_BITS  = $clog2(MAX_COLORS + 1);
   localparam int DIV_BITS   = 16;
   localparam logic [DIV_BITS-1:0] DIV_RESET = 16'd200;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SEARCH = 8'b0000_0010,
      ST_SCAN   = 8'b0000_0100,
      ST_PICK   = 8'b0000_1000,
      ST_TRIM   = 8'b0001_0000,
      ST_TRIMCK = 8'b0010_0000,
      ST_EMIT   = 8'b0100_0000,
      ST_EMITW  = 8'b1000_0000
   } state_type;
endpackage
`default_nettype wire

[rtl/dchr_table.sv]
// Colour table memory: keys, counts and a taken flag per entry, one read port.
`default_nettype none
module dchr_table (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [dchr_pkg::IDX_BITS-1:0]  wr_addr,
   input  wire logic [23:0]                    wr_key,
   input  wire logic [dchr_pkg::COUNT_BITS-1:0] wr_count,
   input  wire logic                           wr_taken,
   input  wire logic [dchr_pkg::IDX_BITS-1:0]  rd_addr,
   output logic      [23:0]                    rd_key,
   output logic      [dchr_pkg::COUNT_BITS-1:0] rd_count,
   output logic                                rd_taken
);
   logic [23:0]                     key_mem   [dchr_pkg::MAX_COLORS];
   logic [dchr_pkg::COUNT_BITS-1:0] count_mem [dchr_pkg::MAX_COLORS];
   logic                            taken_mem [dchr_pkg::MAX_COLORS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         count_mem[wr_addr] <= wr_count;
         taken_mem[wr_addr] <= wr_taken;
      end
      rd_key   <= key_mem[rd_addr];
      rd_count <= count_mem[rd_addr];
      rd_taken <= taken_mem[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/dominant_color_histogram_ranker.sv]
// Top level: histogram build, selection ranking, share trim and palette output.
// Each pixel is matched by a linear table search, one read a cycle.
// Last pixel: a trim pass of n scans, a sweep that clears the taken flags, then k scans.
// Results appear one per emit scan, for n colours with k kept.
// Reset (synchronous) clears counters and the overflow and valid flags; divisor returns to 200.
// The receiver cannot stall; each rsp_ beat lasts one cycle.
`default_nettype none
module dominant_color_histogram_ranker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_pixel_red,
   input  wire logic [7:0]  req_pixel_green,
   input  wire logic [7:0]  req_pixel_blue,
   input  wire logic        req_last_pixel,
   output logic             rsp_valid,
   output logic [7:0]       rsp_color_red,
   output logic [7:0]       rsp_color_green,
   output logic [7:0]       rsp_color_blue,
   output logic [23:0]      rsp_color_count,
   output logic [23:0]      rsp_kept_sum,
   output logic             rsp_table_overflowed,
   output logic             rsp_last_color,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   localparam int IB = dchr_pkg::IDX_BITS;
   localparam int UB = dchr_pkg::USED_BITS;
   localparam int CB = dchr_pkg::COUNT_BITS;

   dchr_pkg::state_type state_ff, state_in;
   logic [15:0]  div_ff, div_in;
   logic [UB-1:0] used_ff, used_in;
   logic [CB-1:0] total_ff, total_in;
   logic          ovf_ff, ovf_in;
   logic [23:0]   key_ff, key_in;
   logic          last_ff, last_in;
   logic [UB-1:0] ptr_ff, ptr_in;     // address issued
   logic [UB-1:0] chk_ff, chk_in;     // address whose data is arriving
   logic [UB-1:0] kept_ff, kept_in;   // palette size after trim
   logic [UB-1:0] rank_ff, rank_in;   // ranks finished
   logic          best_v_ff, best_v_in;
   logic [IB-1:0] best_i_ff, best_i_in;
   logic [CB-1:0] best_c_ff, best_c_in;
   logic [23:0]   best_k_ff, best_k_in;
   logic [CB-1:0] sum_ff, sum_in;
   logic          pass_ff, pass_in;   // 0: trim scan, 1: emit scan
   logic [CB+15:0] prod_ff, prod_in;

   logic          wr_en, wr_taken, rd_taken;
   logic [IB-1:0] wr_addr, rd_addr;
   logic [23:0]   wr_key, rd_key;
   logic [CB-1:0] wr_count, rd_count;

   logic          rv_ff, rv_in;
   logic [23:0]   rk_ff, rk_in;
   logic [CB-1:0] rc_ff, rc_in, rs_ff, rs_in;
   logic          ro_ff, ro_in, rl_ff, rl_in;

   dchr_table u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key),
      .wr_count(wr_count), .wr_taken(wr_taken), .rd_addr(rd_addr),
      .rd_key(rd_key), .rd_count(rd_count), .rd_taken(rd_taken)
   );

   assign busy      = (state_ff != dchr_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rd_addr   = ptr_ff[IB-1:0];

   function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
      return (v == dchr_pkg::COUNT_MAX) ? v : v + 1'b1;
   endfunction

   always_comb begin
      logic [CB:0] s;
      state_in = state_ff; div_in = div_ff; used_in = used_ff; total_in = total_ff;
      ovf_in = ovf_ff; key_in = key_ff; last_in = last_ff; ptr_in = ptr_ff;
      chk_in = chk_ff; kept_in = kept_ff; rank_in = rank_ff; best_v_in = best_v_ff;
      best_i_in = best_i_ff; best_c_in = best_c_ff; best_k_in = best_k_ff;
      sum_in = sum_ff; pass_in = pass_ff; prod_in = prod_ff;
      wr_en = 1'b0; wr_addr = chk_ff[IB-1:0]; wr_key = rd_key;
      wr_count = rd_count; wr_taken = 1'b0;
      rv_in = 1'b0; rk_in = rk_ff; rc_in = rc_ff; rs_in = rs_ff; ro_in = ro_ff; rl_in = rl_ff;
      s = '0;
      if (csr_valid) div_in = csr_data;
      unique case (state_ff)
         dchr_pkg::ST_IDLE: begin
            if (start) begin
               key_in   = {req_pixel_red, req_pixel_green, req_pixel_blue};
               last_in  = req_last_pixel;
               total_in = sat_inc(total_ff);
               ptr_in   = '0;
               chk_in   = '0;
               state_in = dchr_pkg::ST_SEARCH;
            end
         end
         dchr_pkg::ST_SEARCH: begin
            // ptr leads chk by one: read data for chk arrives this cycle
            if (chk_ff != ptr_ff && rd_key == key_ff) begin
               wr_en = 1'b1; wr_count = sat_inc(rd_count);
               state_in = dchr_pkg::ST_SCAN;
               ptr_in = '0; chk_in = '0;
            end else if (ptr_ff == used_ff && chk_ff == used_ff) begin
               if (used_ff < UB'(dchr_pkg::MAX_COLORS)) begin
                  wr_en = 1'b1; wr_addr = used_ff[IB-1:0];
                  wr_key = key_ff; wr_count = CB'(1);
                  used_in = used_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = dchr_pkg::ST_SCAN;
               ptr_in = '0; chk_in = '0;
            end else begin
               chk_in = ptr_ff;
               if (ptr_ff != used_ff) ptr_in = ptr_ff + 1'b1;
            end
            if (state_in == dchr_pkg::ST_SCAN) begin
               if (!last_ff) state_in = dchr_pkg::ST_IDLE;
               rank_in = '0; best_v_in = 1'b0; pass_in = 1'b0;
               kept_in = used_in; sum_in = '0;
            end
         end
         dchr_pkg::ST_SCAN: begin
            // selection pass: find largest untaken count, first index wins ties
            if (chk_ff != ptr_ff) begin
               if (!rd_taken && (!best_v_ff || rd_count > best_c_ff)) begin
                  best_v_in = 1'b1; best_c_in = rd_count; best_k_in = rd_key;
                  best_i_in = chk_ff[IB-1:0];
               end
            end
            if (ptr_ff == used_ff && chk_ff == used_ff) begin
               state_in = dchr_pkg::ST_PICK;
            end else begin
               chk_in = ptr_ff;
               if (ptr_ff != used_ff) ptr_in = ptr_ff + 1'b1;
            end
         end
         dchr_pkg::ST_PICK: begin
            wr_en = 1'b1; wr_addr = best_i_ff; wr_key = best_k_ff;
            wr_count = best_c_ff; wr_taken = 1'b1;
            prod_in = (CB+16)'(best_c_ff) * (CB+16)'(div_ff);
            state_in = pass_ff ? dchr_pkg::ST_EMIT : dchr_pkg::ST_TRIM;
         end
         dchr_pkg::ST_TRIM: begin
            // first pass: the first rank past rank 0 that falls below the share sets kept
            if (rank_ff != '0 && prod_ff < (CB+16)'(total_ff)
                && kept_in == used_ff) kept_in = rank_ff;
            state_in = dchr_pkg::ST_TRIMCK;
         end
         dchr_pkg::ST_TRIMCK: begin
            rank_in = rank_ff + 1'b1; best_v_in = 1'b0; ptr_in = '0; chk_in = '0;
            state_in = dchr_pkg::ST_SCAN;
            if (rank_ff + 1'b1 == used_ff) begin
               // restart for emit: clear taken flags by rewriting
               pass_in = 1'b1; rank_in = '0; ptr_in = '0; chk_in = '0;
               state_in = dchr_pkg::ST_EMITW;
            end
         end
         dchr_pkg::ST_EMITW: begin
            // clear taken flags, one entry a cycle, via read then write back
            if (chk_ff != ptr_ff) begin
               wr_en = 1'b1; wr_taken = 1'b0;
            end
            if (ptr_ff == used_ff && chk_ff == used_ff) begin
               ptr_in = '0; chk_in = '0; best_v_in = 1'b0;
               state_in = dchr_pkg::ST_SCAN;
            end else begin
               chk_in = ptr_ff;
               if (ptr_ff != used_ff) ptr_in = ptr_ff + 1'b1;
            end
         end
         dchr_pkg::ST_EMIT: begin
            s = {1'b0, sum_ff} + {1'b0, best_c_ff};
            sum_in = s[CB] ? dchr_pkg::COUNT_MAX : s[CB-1:0];
            rv_in = 1'b1; rk_in = best_k_ff; rc_in = best_c_ff; rs_in = sum_in;
            ro_in = ovf_ff; rl_in = (rank_ff + 1'b1 == kept_ff);
            rank_in = rank_ff + 1'b1; best_v_in = 1'b0; ptr_in = '0; chk_in = '0;
            state_in = dchr_pkg::ST_SCAN;
            if (rl_in) begin
               used_in = '0; total_in = '0; ovf_in = 1'b0;
               state_in = dchr_pkg::ST_IDLE;
            end
         end
         default: state_in = dchr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dchr_pkg::ST_IDLE;
         div_ff   <= dchr_pkg::DIV_RESET;
         used_ff  <= '0;
         total_ff <= '0;
         ovf_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         div_ff   <= div_in;
         used_ff  <= used_in;
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
         rv_ff    <= rv_in;
      end
      key_ff <= key_in; last_ff <= last_in; ptr_ff <= ptr_in; chk_ff <= chk_in;
      kept_ff <= kept_in; rank_ff <= rank_in; best_v_ff <= best_v_in;
      best_i_ff <= best_i_in; best_c_ff <= best_c_in; best_k_ff <= best_k_in;
      sum_ff <= sum_in; pass_ff <= pass_in; prod_ff <= prod_in;
      rk_ff <= rk_in; rc_ff <= rc_in; rs_ff <= rs_in; ro_ff <= ro_in; rl_ff <= rl_in;
   end

   assign rsp_valid            = rv_ff;
   assign rsp_color_red        = rk_ff[23:16];
   assign rsp_color_green      = rk_ff[15:8];
   assign rsp_color_blue       = rk_ff[7:0];
   assign rsp_color_count      = 24'(rc_ff);
   assign rsp_kept_sum         = 24'(rs_ff);
   assign rsp_table_overflowed = ro_ff;
   assign rsp_last_color       = rl_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UB'(dchr_pkg::MAX_COLORS)) else $error("table fill beyond depth");
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rv_in |-> state_ff == dchr_pkg::ST_EMIT) else $error("result outside emit");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rl_ff) |-> used_ff == '0 && !busy) else $error("state not cleared");
`endif
endmodule
`default_nettype wire
